@@ rtl/rans_byte_encoder_macros.svh @@
// Assertion helpers used by rbe_ctrl.
`ifndef RANS_BYTE_ENCODER_MACROS_SVH
`define RANS_BYTE_ENCODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RBE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RBE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rbe_pkg.sv @@
package rbe_pkg;

    localparam int BYTE_W     = 8;
    localparam int OPCODE_W   = 2;
    localparam int SYMBOL_W   = 8;
    localparam int FREQ_W     = 13;
    localparam int START_W    = 12;
    localparam int STATE_W    = 32;
    localparam int TABLE_DEPTH = 256;
    localparam int DIV_CNT_W  = $clog2(STATE_W);
    localparam int FLUSH_CNT_W = 2;

    localparam logic [OPCODE_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ENCODE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_FLUSH  = 2'd2;

    localparam logic [FLUSH_CNT_W-1:0] FLUSH_LAST = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_FINISH,
        ST_FLUSH
    } ctrl_state_t;

    typedef enum logic [1:0] {
        OUT_LOW,
        OUT_HIGH,
        OUT_BAD
    } out_sel_t;

    typedef struct packed {
        logic     tbl_write;
        logic     tbl_read;
        logic     work_load;
        logic     work_shr;
        logic     work_shl;
        logic     div_init;
        logic     div_step;
        logic     state_update;
        logic     state_reset;
        logic     out_load;
        out_sel_t out_sel;
        logic     out_last;
    } dp_cmd_t;

    typedef struct packed {
        logic f_zero;
        logic ge_bound;
        logic ge_bound_next;
        logic div_done;
    } dp_status_t;

endpackage

@@ rtl/rans_byte_encoder.sv @@
// Byte-wise rANS encoder.
// Input channel (in_valid / in_stall) carries one request per item: opcode selects
// load table entry, encode symbol or flush. A request is taken when in_valid is high
// and in_stall is low. Symbols are fed in reverse source order.
// Output channel (out_valid / out_stall) carries emitted bytes, zero to four per
// request, with last_of_run on the final byte of an item and bad_symbol on a
// zero-frequency symbol.
// Sequence: a load writes its table entry when it is taken. An encode reads the
// table on the accept edge, emits its renormalization bytes (0 to 2), sets up the
// divider, runs the 32-step radix-2 restoring divider and then updates the state.
// A zero-frequency symbol returns to idle once its byte is loaded. The first byte
// of an item is loaded into the output register from the check or flush state.
// A flush emits four bytes, most significant first.
// The output register lets the next request be taken while a byte still waits.
// When the receiver stalls, the pending byte holds and byte emission pauses.
// Reset (rst_n low, asynchronous) returns the coder state to 2^L_BITS and empties the
// output register. The symbol tables are not cleared; load them before encoding.
module rans_byte_encoder
    import rbe_pkg::*;
#(
    parameter int SCALE_BITS = 12,
    parameter int L_BITS     = 23
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [OPCODE_W-1:0] opcode,
    input  logic [SYMBOL_W-1:0] symbol,
    input  logic [FREQ_W-1:0]   sym_freq,
    input  logic [START_W-1:0]  sym_start,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [BYTE_W-1:0]   out_byte,
    output logic                last_of_run,
    output logic                bad_symbol
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: handshakes, renormalization loop, divider steps, flush count
    rbe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // tables, coder state, shared divider and output register
    rbe_datapath #(
        .SCALE_BITS (SCALE_BITS),
        .L_BITS     (L_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .symbol      (symbol),
        .sym_freq    (sym_freq),
        .sym_start   (sym_start),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .bad_symbol  (bad_symbol)
    );

endmodule

@@ rtl/rbe_datapath.sv @@
module rbe_datapath
    import rbe_pkg::*;
#(
    parameter int SCALE_BITS = 12,
    parameter int L_BITS     = 23
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    output dp_status_t          status,
    input  logic [SYMBOL_W-1:0] symbol,
    input  logic [FREQ_W-1:0]   sym_freq,
    input  logic [START_W-1:0]  sym_start,
    output logic [BYTE_W-1:0]   out_byte,
    output logic                last_of_run,
    output logic                bad_symbol
);

    localparam int BOUND_SHIFT = L_BITS - SCALE_BITS + 8;
    localparam int CMP_W = (FREQ_W + BOUND_SHIFT > STATE_W) ? FREQ_W + BOUND_SHIFT : STATE_W;
    localparam logic [STATE_W-1:0] STATE_INIT = STATE_W'(1) << L_BITS;

    logic [FREQ_W-1:0]    freq_mem [TABLE_DEPTH];
    logic [START_W-1:0]   start_mem [TABLE_DEPTH];
    logic [FREQ_W-1:0]    freq_rd_reg;
    logic [START_W-1:0]   start_rd_reg;

    logic [STATE_W-1:0]   state_reg, state_next;
    logic [STATE_W-1:0]   work_reg, work_next;
    logic [FREQ_W-1:0]    rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    logic [BYTE_W-1:0]    out_byte_reg, out_byte_next;
    logic                 out_last_reg;
    logic                 out_bad_reg, out_bad_next;

    logic [CMP_W-1:0]     bound;
    logic [FREQ_W:0]      rem_sh;
    logic [FREQ_W:0]      rem_diff;
    logic                 rem_ge;

    // table memories: write on load, registered read on encode
    always_ff @(posedge clk)
    begin
        if (cmd.tbl_write)
        begin
            freq_mem[symbol]  <= sym_freq;
            start_mem[symbol] <= sym_start;
        end
        if (cmd.tbl_read)
        begin
            freq_rd_reg  <= freq_mem[symbol];
            start_rd_reg <= start_mem[symbol];
        end
    end

    assign bound = CMP_W'(freq_rd_reg) << BOUND_SHIFT;

    assign status.f_zero        = (freq_rd_reg == '0);
    assign status.ge_bound      = (CMP_W'(work_reg) >= bound);
    assign status.ge_bound_next = (CMP_W'(work_reg >> BYTE_W) >= bound);
    assign status.div_done      = (div_cnt_reg == DIV_CNT_W'(STATE_W - 1));

    // restoring divider step, quotient shifts into the work register
    assign rem_sh   = {rem_reg, work_reg[STATE_W-1]};
    assign rem_diff = rem_sh - {1'b0, freq_rd_reg};
    assign rem_ge   = (rem_sh >= {1'b0, freq_rd_reg});

    always_comb
    begin
        work_next    = work_reg;
        rem_next     = rem_reg;
        div_cnt_next = div_cnt_reg;
        if (cmd.work_load)
        begin
            work_next = state_reg;
        end
        else if (cmd.work_shr)
        begin
            work_next = work_reg >> BYTE_W;
        end
        else if (cmd.work_shl)
        begin
            work_next = work_reg << BYTE_W;
        end
        else if (cmd.div_step)
        begin
            work_next = {work_reg[STATE_W-2:0], rem_ge};
        end
        if (cmd.div_init)
        begin
            rem_next     = '0;
            div_cnt_next = '0;
        end
        else if (cmd.div_step)
        begin
            rem_next     = rem_ge ? rem_diff[FREQ_W-1:0] : rem_sh[FREQ_W-1:0];
            div_cnt_next = div_cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        if (cmd.state_reset)
        begin
            state_next = STATE_INIT;
        end
        else if (cmd.state_update)
        begin
            state_next = (work_reg << SCALE_BITS) + STATE_W'(rem_reg) + STATE_W'(start_rd_reg);
        end
    end

    always_comb
    begin
        case (cmd.out_sel)
            OUT_LOW:
            begin
                out_byte_next = work_reg[BYTE_W-1:0];
                out_bad_next  = 1'b0;
            end
            OUT_HIGH:
            begin
                out_byte_next = work_reg[STATE_W-1 -: BYTE_W];
                out_bad_next  = 1'b0;
            end
            OUT_BAD:
            begin
                out_byte_next = '0;
                out_bad_next  = 1'b1;
            end
            default:
            begin
                out_byte_next = '0;
                out_bad_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= STATE_INIT;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        if (cmd.out_load)
        begin
            out_byte_reg <= out_byte_next;
            out_last_reg <= cmd.out_last;
            out_bad_reg  <= out_bad_next;
        end
    end

    assign out_byte    = out_byte_reg;
    assign last_of_run = out_last_reg;
    assign bad_symbol  = out_bad_reg;

endmodule

@@ rtl/rbe_ctrl.sv @@
`include "rans_byte_encoder_macros.svh"

module rbe_ctrl
    import rbe_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [OPCODE_W-1:0] opcode,
    output logic                out_valid,
    input  logic                out_stall,
    input  dp_status_t          status,
    output dp_cmd_t             cmd
);

    ctrl_state_t             state_reg, state_next;
    logic [FLUSH_CNT_W-1:0]  flush_cnt_reg, flush_cnt_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_free;
    logic                    in_accept;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && opcode == OP_ENCODE)
                begin
                    state_next = ST_CHECK;
                end
                else if (in_accept && opcode == OP_FLUSH)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_CHECK:
            begin
                if (status.f_zero)
                begin
                    if (out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (!status.ge_bound)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            ST_FLUSH:
            begin
                if (out_free && flush_cnt_reg == FLUSH_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd            = '0;
        cmd.out_sel    = OUT_LOW;
        flush_cnt_next = flush_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    cmd.tbl_write  = (opcode == OP_LOAD);
                    cmd.tbl_read   = (opcode == OP_ENCODE);
                    cmd.work_load  = (opcode == OP_ENCODE) || (opcode == OP_FLUSH);
                    flush_cnt_next = '0;
                end
            end
            ST_CHECK:
            begin
                if (status.f_zero)
                begin
                    cmd.out_load = out_free;
                    cmd.out_sel  = OUT_BAD;
                    cmd.out_last = 1'b1;
                end
                else if (status.ge_bound)
                begin
                    cmd.out_load = out_free;
                    cmd.work_shr = out_free;
                    cmd.out_sel  = OUT_LOW;
                    cmd.out_last = !status.ge_bound_next;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.state_update = 1'b1;
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    cmd.out_load    = 1'b1;
                    cmd.out_sel     = OUT_HIGH;
                    cmd.out_last    = (flush_cnt_reg == FLUSH_LAST);
                    cmd.work_shl    = 1'b1;
                    cmd.state_reset = (flush_cnt_reg == FLUSH_LAST);
                    flush_cnt_next  = flush_cnt_reg + 1'b1;
                end
            end
            default:
            begin
                cmd.out_sel = OUT_LOW;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            flush_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            flush_cnt_reg <= flush_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `RBE_ASSERT_SAME(a_no_overwrite, clk, rst_n, cmd.out_load, !out_valid_reg || !out_stall, "result overwritten while stalled")
    `RBE_ASSERT_NEXT(a_div_runs, clk, rst_n, state_reg == ST_DIV && !status.div_done, state_reg == ST_DIV, "divider left early")
    `RBE_ASSERT_NEXT(a_flush_ends, clk, rst_n, state_reg == ST_FLUSH && cmd.out_load && cmd.out_last, state_reg == ST_IDLE, "flush did not end after last byte")
    `RBE_ASSERT_SAME(a_update_quiet, clk, rst_n, cmd.state_update, !cmd.out_load && !cmd.div_step, "state update overlaps other work")

endmodule
